// ===== hdl/lpsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsrm_pkg
// Shared types and constants for the lidar packet sector range map.
// ----------------------------------------------------------------------------
package lpsrm_pkg;

  // Default bin count of the range map, one bin per degree
  localparam int ANGLE_BINS_DEF = 360;

  // Field widths
  localparam int ANGLE_W  = 9;
  localparam int DIST_W   = 16;
  localparam int TS_W     = 32;
  localparam int RESULT_W = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PKT_POS_W  = 3;

  // Distance reported for a bin that has gone stale (99.9 m in quarter mm)
  localparam logic [RESULT_W-1:0] STALE_DISTANCE = RESULT_W'(399600);

  // Command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALE_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] STALE_WINDOW_RST = CFG_DATA_W'(500);
  localparam logic [CFG_DATA_W-1:0] MAX_RANGE_RST    = CFG_DATA_W'(48000);

  // Last byte position of a measurement packet
  localparam logic [PKT_POS_W-1:0] PKT_LAST_POS = PKT_POS_W'(4);

  // One bin of the range map
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [TS_W-1:0]   ts;
  } bin_entry_t;

  // Write request into the bin memory
  typedef struct packed {
    logic              we;
    logic [ANGLE_W-1:0] addr;
    bin_entry_t        data;
  } bin_wr_t;

  // Read request into the bin memory
  typedef struct packed {
    logic              re;
    logic [ANGLE_W-1:0] addr;
  } bin_rd_t;

endpackage

// ===== hdl/lpsrm_bin_ram.sv =====
// ----------------------------------------------------------------------------
// lpsrm_bin_ram
// Bin memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpsrm_bin_ram
  import lpsrm_pkg::*;
#(
  parameter int ANGLE_BINS = ANGLE_BINS_DEF
) (
  input  logic       clk,
  input  bin_wr_t    wr,
  input  bin_rd_t    rd,
  output bin_entry_t rd_data
);

  localparam int BinAw = $clog2(ANGLE_BINS);

  bin_entry_t mem [ANGLE_BINS];
  bin_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr[BinAw-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data_r <= mem[rd.addr[BinAw-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lpsrm_pkt_asm.sv =====
// ----------------------------------------------------------------------------
// lpsrm_pkt_asm
// Packet assembler: hunts for sync, gathers five bytes, checks the packet
// and issues the bin write for an accepted measurement.
// ----------------------------------------------------------------------------
module lpsrm_pkt_asm
  import lpsrm_pkg::*;
#(
  parameter int ANGLE_BINS = ANGLE_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_stb,
  input  logic [7:0]            byte_value,
  input  logic [TS_W-1:0]       now_ms,
  input  logic [CFG_DATA_W-1:0] max_range_raw,
  output bin_wr_t               wr
);

  logic [7:0]           pkt_byte_r [4];
  logic [PKT_POS_W-1:0] pos_r;
  logic [PKT_POS_W-1:0] pos_nxt;
  logic [ANGLE_W-1:0]   angle;
  logic [DIST_W-1:0]    raw_dist;
  logic                 pkt_ok;

  // Angle bin is the upper nine bits of the 16-bit angle word
  assign angle    = {pkt_byte_r[2], pkt_byte_r[1][7]};
  assign raw_dist = {byte_value, pkt_byte_r[3]};

  always_comb begin
    pkt_ok = (pkt_byte_r[0][0] != pkt_byte_r[0][1])
          && (pkt_byte_r[0][7:2] != 6'd0)
          && (angle < ANGLE_W'(ANGLE_BINS))
          && (raw_dist != '0)
          && (raw_dist <= max_range_raw);
  end

  always_comb begin
    pos_nxt = pos_r;
    if (byte_stb) begin
      if (pos_r == '0) begin
        if (byte_value[0]) begin
          pos_nxt = PKT_POS_W'(1);
        end
      end else if (pos_r == PKT_LAST_POS) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PKT_POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < 4; i++) begin
        pkt_byte_r[i] <= '0;
      end
    end else begin
      pos_r <= pos_nxt;
      if (byte_stb && (pos_r != PKT_LAST_POS) && ((pos_r != '0) || byte_value[0])) begin
        pkt_byte_r[pos_r[1:0]] <= byte_value;
      end
    end
  end

  assign wr.we            = byte_stb && (pos_r == PKT_LAST_POS) && pkt_ok;
  assign wr.addr          = angle;
  assign wr.data.distance = raw_dist;
  assign wr.data.ts       = now_ms;

endmodule

// ===== hdl/lidar_packet_sector_range_map.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_sector_range_map
// Lidar measurement decoder with a one-degree range map and sector minimum.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per transfer. A byte item
//   (in_command = CMD_BYTE) feeds the packet assembler;
//   it produces no result. A query item (in_command = CMD_QUERY) walks the
//   bins from in_start_angle to in_end_angle, wrapping past the last bin,
//   and produces one result transfer on the out channel with the smallest
//   fresh distance, or 399600 when no bin in the sector is fresh.
//   The number of bins a query walks is 1 to 512 with out-of-range
//   angles; the single read port of the bin memory reads them one bin
//   per cycle. One item is worked on at a time: in_ready rises with the
//   result, so the next item transfers only after a query's result shows.
//   Reset runs a clearing pass over every bin of the memory with in_ready
//   low; configuration writes are taken during it.
//   The result sits in an output register; while the receiver stalls,
//   byte items keep flowing, and a finished query holds until the
//   pending result has been taken.
// ----------------------------------------------------------------------------
module lidar_packet_sector_range_map
  import lpsrm_pkg::*;
#(
  parameter int ANGLE_BINS = ANGLE_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_byte_value,
  input  logic [TS_W-1:0]       in_now_ms,
  input  logic [ANGLE_W-1:0]    in_start_angle,
  input  logic [ANGLE_W-1:0]    in_end_angle,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RESULT_W-1:0]   out_min_distance,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;

  localparam logic [ANGLE_W-1:0] LastBin = ANGLE_W'(ANGLE_BINS - 1);
  localparam logic [ANGLE_W-1:0] NumBins = ANGLE_W'(ANGLE_BINS);

  // Configuration registers
  logic [CFG_DATA_W-1:0] stale_window_r;
  logic [CFG_DATA_W-1:0] max_range_r;

  // Control state
  logic [2:0]          state_r, state_nxt;
  logic [ANGLE_W-1:0]  clr_r, clr_nxt;
  logic [ANGLE_W-1:0]  a_r, a_nxt;
  logic [ANGLE_W-1:0]  last_r, last_nxt;
  logic [ANGLE_W-1:0]  end_r, end_nxt;
  logic                wrap_pend_r, wrap_pend_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                rd_vld_r, rd_last_r;
  logic                val_vld_r, val_last_r;
  logic                out_valid_r, out_valid_nxt;

  // Payload
  logic [TS_W-1:0]     now_r;
  logic [RESULT_W-1:0] val_r;
  logic [RESULT_W-1:0] best_r, best_nxt;
  logic [RESULT_W-1:0] out_dist_r;

  logic                in_xfer, query_xfer, byte_xfer;
  logic                issue_last;
  logic                load_out;
  logic [ANGLE_W-1:0]  rd_idx;
  logic [TS_W-1:0]     age;
  logic [RESULT_W-1:0] best_step;

  bin_wr_t    pkt_wr, ram_wr;
  bin_rd_t    ram_rd;
  bin_entry_t rd_data;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign query_xfer = in_xfer && (in_command == CMD_QUERY);
  assign byte_xfer  = in_xfer && (in_command == CMD_BYTE);
  assign cfg_ready  = 1'b1;

  // Configuration writes land at once; the user must send them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_window_r <= STALE_WINDOW_RST;
      max_range_r    <= MAX_RANGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STALE_WINDOW: stale_window_r <= cfg_data;
        REG_MAX_RANGE:    max_range_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  lpsrm_pkt_asm #(
    .ANGLE_BINS(ANGLE_BINS)
  ) u_pkt_asm (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stb     (byte_xfer),
    .byte_value   (in_byte_value),
    .now_ms       (in_now_ms),
    .max_range_raw(max_range_r),
    .wr           (pkt_wr)
  );

  // Clearing pass owns the write port after reset; bytes only arrive later
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = clr_r;
      ram_wr.data = '0;
    end else begin
      ram_wr = pkt_wr;
    end
  end

  // Fold the walk address back into the map
  assign rd_idx      = (a_r >= NumBins) ? (a_r - NumBins) : a_r;
  assign ram_rd.re   = (state_r == ST_WALK) && !issue_done_r;
  assign ram_rd.addr = rd_idx;
  assign issue_last  = ram_rd.re && (a_r == last_r) && !wrap_pend_r;

  lpsrm_bin_ram #(
    .ANGLE_BINS(ANGLE_BINS)
  ) u_bin_ram (
    .clk    (clk),
    .wr     (ram_wr),
    .rd     (ram_rd),
    .rd_data(rd_data)
  );

  // Age check on the read word; a register follows before the running min
  assign age = now_r - rd_data.ts;

  assign best_step = (val_r < best_r) ? val_r : best_r;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    a_nxt          = a_r;
    last_nxt       = last_r;
    end_nxt        = end_r;
    wrap_pend_nxt  = wrap_pend_r;
    issue_done_nxt = issue_done_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ANGLE_W'(1);
        if (clr_r == LastBin) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (query_xfer) begin
          state_nxt      = ST_WALK;
          issue_done_nxt = 1'b0;
          best_nxt       = STALE_DISTANCE;
          end_nxt        = in_end_angle;
          if (in_start_angle <= in_end_angle) begin
            // Straight run, each angle folded on read
            a_nxt         = in_start_angle;
            last_nxt      = in_end_angle;
            wrap_pend_nxt = 1'b0;
          end else if (in_start_angle < NumBins) begin
            // Run to the last bin, then restart at zero
            a_nxt         = in_start_angle;
            last_nxt      = LastBin;
            wrap_pend_nxt = 1'b1;
          end else begin
            // Upper part is empty: only zero up to end
            a_nxt         = '0;
            last_nxt      = in_end_angle;
            wrap_pend_nxt = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (ram_rd.re) begin
          if (a_r == last_r) begin
            if (wrap_pend_r) begin
              a_nxt         = '0;
              last_nxt      = end_r;
              wrap_pend_nxt = 1'b0;
            end else begin
              issue_done_nxt = 1'b1;
            end
          end else begin
            a_nxt = a_r + ANGLE_W'(1);
          end
        end
        if (val_vld_r) begin
          best_nxt = best_step;
          if (val_last_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      a_r          <= '0;
      last_r       <= '0;
      end_r        <= '0;
      wrap_pend_r  <= 1'b0;
      issue_done_r <= 1'b1;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      val_vld_r    <= 1'b0;
      val_last_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      a_r          <= a_nxt;
      last_r       <= last_nxt;
      end_r        <= end_nxt;
      wrap_pend_r  <= wrap_pend_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= ram_rd.re;
      rd_last_r    <= issue_last;
      val_vld_r    <= rd_vld_r;
      val_last_r   <= rd_vld_r && rd_last_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      now_r <= in_now_ms;
    end
    if (rd_vld_r) begin
      val_r <= (age > TS_W'(stale_window_r)) ? STALE_DISTANCE
                                             : RESULT_W'(rd_data.distance);
    end
    best_r <= best_nxt;
    if (load_out) begin
      out_dist_r <= best_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_distance = out_dist_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Bin memory is never written while a sector walk reads it
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !ram_wr.we)
    else $error("bin write during sector walk");

  // Every read address stays inside the map
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd.re |-> (ram_rd.addr < NumBins))
    else $error("bin read address out of range");

  // A query transfer starts a walk with its first read in the next cycle
  a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    query_xfer |=> ((state_r == ST_WALK) && ram_rd.re))
    else $error("query did not start a walk");

  // A presented result never exceeds the stale distance
  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r <= STALE_DISTANCE))
    else $error("result above stale distance");

endmodule
